// File: hdl/ffaza_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffaza_pkg
// Types and codes shared by the aligned first-fit zone allocator.
// ----------------------------------------------------------------------------
package ffaza_pkg;

    localparam int DataW = 16;

    // Request operation codes
    localparam logic OP_RESERVE = 1'b0;
    localparam logic OP_FREE    = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Configuration register indexes
    localparam logic CFG_POOL_BASE = 1'b0;
    localparam logic CFG_POOL_SIZE = 1'b1;

    typedef struct packed {
        logic [DataW-1:0] base;
        logic [DataW-1:0] size;
    } zone_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_RD,
        S_WAIT,
        S_DIV,
        S_RCHK,
        S_FCHK,
        S_DECIDE,
        S_EXEC,
        S_SD,
        S_SDW,
        S_SU,
        S_SUW,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        RD_IDX,
        RD_PTR_NEXT,
        RD_PTR_PREV
    } rd_sel_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_PRIM,
        WR_SHDN,
        WR_SHUP,
        WR_INS
    } wr_sel_t;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_IDX,
        PTR_CNT,
        PTR_INC,
        PTR_DEC
    } ptr_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    // Controller to datapath
    typedef struct packed {
        logic       idle;
        logic       cap;
        logic       div_start;
        logic       adv;
        logic       decide;
        logic       set_st;
        logic [1:0] st_code;
        logic       out_load;
        rd_sel_t    rd_sel;
        wr_sel_t    wr_sel;
        ptr_op_t    ptr_op;
        cnt_op_t    cnt_op;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic req_fire;
        logic is_free;
        logic cnt_zero;
        logic scan_last;
        logic div_done;
        logic fit;
        logic brk;
        logic need_wr;
        logic need_drop;
        logic need_ins;
        logic full_err;
        logic sd_more;
        logic su_more;
        logic out_free;
    } stat_t;

endpackage

// File: hdl/ffaza_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffaza_if
// Request, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ffaza_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [15:0] block_length;
    logic [15:0] block_start;
    logic [15:0] align_to;
    modport source (output valid, operation, block_length, block_start, align_to,
                    input ready);
    modport sink   (input valid, operation, block_length, block_start, align_to,
                    output ready);
endinterface

interface ffaza_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] granted_start;
    modport source (output valid, status, granted_start, input ready);
    modport sink   (input valid, status, granted_start, output ready);
endinterface

interface ffaza_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/ffaza_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffaza_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffaza_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/ffaza_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffaza_ctrl
// Sequencer: scan, decide, write/shift and result hand-off.
// ----------------------------------------------------------------------------
module ffaza_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  ffaza_pkg::stat_t stat,
    output ffaza_pkg::cmd_t  cmd
);
    import ffaza_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (stat.req_fire) state_next = S_START;
            S_START:
            begin
                if (!stat.cnt_zero)    state_next = S_RD;
                else if (stat.is_free) state_next = S_DECIDE;
                else                   state_next = S_DONE;
            end
            S_RD:     state_next = S_WAIT;
            S_WAIT:   state_next = stat.is_free ? S_FCHK : S_DIV;
            S_DIV:    if (stat.div_done) state_next = S_RCHK;
            S_RCHK:
            begin
                if (stat.fit)            state_next = S_DECIDE;
                else if (stat.scan_last) state_next = S_DONE;
                else                     state_next = S_RD;
            end
            S_FCHK:
            begin
                if (stat.brk || stat.scan_last) state_next = S_DECIDE;
                else                            state_next = S_RD;
            end
            S_DECIDE: state_next = S_EXEC;
            S_EXEC:
            begin
                if (stat.full_err)       state_next = S_DONE;
                else if (stat.need_drop) state_next = S_SD;
                else if (stat.need_ins)  state_next = S_SU;
                else                     state_next = S_DONE;
            end
            S_SD:     state_next = stat.sd_more ? S_SDW : S_DONE;
            S_SDW:    state_next = S_SD;
            S_SU:     state_next = stat.su_more ? S_SUW : S_DONE;
            S_SUW:    state_next = S_SU;
            S_DONE:   if (stat.out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Command outputs
    always_comb
    begin
        cmd           = '0;
        cmd.rd_sel    = RD_IDX;
        cmd.wr_sel    = WR_NONE;
        cmd.ptr_op    = PTR_HOLD;
        cmd.cnt_op    = CNT_HOLD;
        cmd.st_code   = ST_OK;
        case (state_reg)
            S_IDLE:   cmd.idle = 1'b1;
            S_START:
            begin
                if (stat.cnt_zero && !stat.is_free)
                begin
                    cmd.set_st  = 1'b1;
                    cmd.st_code = ST_NOFIT;
                end
            end
            S_RD:     cmd.rd_sel = RD_IDX;
            S_WAIT:
            begin
                cmd.cap       = 1'b1;
                cmd.div_start = !stat.is_free;
            end
            S_DIV:    cmd.rd_sel = RD_IDX;
            S_RCHK:
            begin
                if (!stat.fit && stat.scan_last)
                begin
                    cmd.set_st  = 1'b1;
                    cmd.st_code = ST_NOFIT;
                end
                else if (!stat.fit)
                begin
                    cmd.adv = 1'b1;
                end
            end
            S_FCHK:   cmd.adv = !stat.brk;
            S_DECIDE: cmd.decide = 1'b1;
            S_EXEC:
            begin
                if (stat.full_err)
                begin
                    cmd.set_st  = 1'b1;
                    cmd.st_code = ST_FULL;
                end
                else
                begin
                    if (stat.need_wr) cmd.wr_sel = WR_PRIM;
                    cmd.ptr_op = stat.need_drop ? PTR_IDX : PTR_CNT;
                    if (!stat.need_drop && !stat.need_ins) cmd.set_st = 1'b1;
                end
            end
            S_SD:
            begin
                if (stat.sd_more)
                begin
                    cmd.rd_sel = RD_PTR_NEXT;
                end
                else
                begin
                    cmd.cnt_op = CNT_DEC;
                    cmd.set_st = 1'b1;
                end
            end
            S_SDW:
            begin
                cmd.wr_sel = WR_SHDN;
                cmd.ptr_op = PTR_INC;
            end
            S_SU:
            begin
                if (stat.su_more)
                begin
                    cmd.rd_sel = RD_PTR_PREV;
                end
                else
                begin
                    cmd.wr_sel = WR_INS;
                    cmd.cnt_op = CNT_INC;
                    cmd.set_st = 1'b1;
                end
            end
            S_SUW:
            begin
                cmd.wr_sel = WR_SHUP;
                cmd.ptr_op = PTR_DEC;
            end
            S_DONE:   cmd.out_load = stat.out_free;
            default:  cmd.idle = 1'b0;
        endcase
    end

endmodule

// File: hdl/ffaza_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffaza_dp
// Datapath: zone table, alignment divider, merge/split decision, result.
// ----------------------------------------------------------------------------
module ffaza_dp #(
    parameter int MAX_ZONES = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    ffaza_req_if.sink        req,
    ffaza_rsp_if.source      rsp,
    ffaza_cfg_if.sink        cfg,
    input  ffaza_pkg::cmd_t  cmd,
    output ffaza_pkg::stat_t stat
);
    import ffaza_pkg::*;

    localparam int AW = $clog2(MAX_ZONES);
    localparam int CW = $clog2(MAX_ZONES + 1);
    localparam logic [CW-1:0] MaxCnt = CW'(MAX_ZONES);

    // Configuration and table control
    logic [15:0]   pool_base_reg;
    zone_t         init_zone_reg;
    logic [CW-1:0] count_reg;
    logic          init_reg;
    // Latched request
    logic          op_reg;
    logic [15:0]   len_reg;
    logic [15:0]   start_reg;
    logic [15:0]   align_reg;
    // Scan state
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] ptr_reg;
    zone_t         cur_reg;
    zone_t         prev_reg;
    // Divider
    logic          div_busy_reg;
    logic [4:0]    div_cnt_reg;
    logic [15:0]   div_rem_reg;
    logic [15:0]   div_q_reg;
    // Decision
    logic          need_wr_reg;
    logic          need_drop_reg;
    logic          need_ins_reg;
    logic [CW-1:0] wr_addr_reg;
    zone_t         wr_data_reg;
    logic [CW-1:0] ins_addr_reg;
    zone_t         ins_data_reg;
    logic [15:0]   grant_reg;
    logic [1:0]    st_reg;
    // Result register
    logic          out_valid_reg;
    logic [1:0]    out_status_reg;
    logic [15:0]   out_grant_reg;
    // Memory
    logic          rd_ovr_reg;
    logic          we;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic [31:0]   wdata;
    logic [31:0]   rdata;
    zone_t         entry;

    ffaza_ram #(.WIDTH(32), .DEPTH(MAX_ZONES)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Entry 0 reads as the zone captured at the last reload until first written
    assign entry = rd_ovr_reg ? init_zone_reg : zone_t'(rdata);

    logic [CW-1:0] ptr_inc;
    logic [CW-1:0] ptr_dec;
    assign ptr_inc = ptr_reg + CW'(1);
    assign ptr_dec = ptr_reg - CW'(1);

    // Read address
    always_comb
    begin
        case (cmd.rd_sel)
            RD_PTR_NEXT: raddr = ptr_inc[AW-1:0];
            RD_PTR_PREV: raddr = ptr_dec[AW-1:0];
            default:     raddr = idx_reg[AW-1:0];
        endcase
    end

    // Write port
    always_comb
    begin
        we    = 1'b1;
        waddr = ptr_reg[AW-1:0];
        wdata = entry;
        case (cmd.wr_sel)
            WR_PRIM:
            begin
                waddr = wr_addr_reg[AW-1:0];
                wdata = wr_data_reg;
            end
            WR_INS:
            begin
                waddr = ins_addr_reg[AW-1:0];
                wdata = ins_data_reg;
            end
            WR_SHDN, WR_SHUP: we = 1'b1;
            default:          we = 1'b0;
        endcase
    end

    // Alignment offset from divider remainder
    logic [15:0] off;
    logic [16:0] div_trial;
    logic [16:0] need;
    logic [15:0] rest;
    assign off       = (div_rem_reg == 16'd0) ? 16'd0 : align_reg - div_rem_reg;
    assign div_trial = {div_rem_reg, div_q_reg[15]};
    assign need      = {1'b0, off} + {1'b0, len_reg};
    assign rest      = cur_reg.size - off;

    // Free adjacency and merged sizes
    logic        have_prev;
    logic        have_cur;
    logic        prev_adj;
    logic        post_adj;
    logic [17:0] sum_both;
    logic [17:0] sum_prev;
    logic [17:0] sum_post;
    logic [15:0] sat_both;
    logic [15:0] sat_prev;
    logic [15:0] sat_post;
    assign have_prev = idx_reg != '0;
    assign have_cur  = idx_reg < count_reg;
    assign prev_adj  = have_prev &&
                       (({1'b0, prev_reg.base} + {1'b0, prev_reg.size}) == {1'b0, start_reg});
    assign post_adj  = have_cur &&
                       (({1'b0, start_reg} + {1'b0, len_reg}) == {1'b0, cur_reg.base});
    assign sum_both  = {2'b0, prev_reg.size} + {2'b0, len_reg} + {2'b0, cur_reg.size};
    assign sum_prev  = {2'b0, prev_reg.size} + {2'b0, len_reg};
    assign sum_post  = {2'b0, cur_reg.size} + {2'b0, len_reg};
    assign sat_both  = (|sum_both[17:16]) ? 16'hFFFF : sum_both[15:0];
    assign sat_prev  = (|sum_prev[17:16]) ? 16'hFFFF : sum_prev[15:0];
    assign sat_post  = (|sum_post[17:16]) ? 16'hFFFF : sum_post[15:0];

    // Configuration, zone count, read override and divider control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg <= '0;
            init_zone_reg <= '0;
            count_reg     <= CW'(1);
            init_reg      <= 1'b1;
            div_busy_reg  <= 1'b0;
            div_cnt_reg   <= '0;
            rd_ovr_reg    <= 1'b0;
        end
        else
        begin
            rd_ovr_reg <= init_reg && (raddr == '0);
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_POOL_BASE: pool_base_reg <= cfg.data;
                    CFG_POOL_SIZE:
                    begin
                        init_zone_reg <= '{base: pool_base_reg, size: cfg.data};
                        count_reg     <= CW'(1);
                        init_reg      <= 1'b1;
                    end
                    default: pool_base_reg <= pool_base_reg;
                endcase
            end
            else
            begin
                if (we && waddr == '0) init_reg <= 1'b0;
                case (cmd.cnt_op)
                    CNT_INC: count_reg <= count_reg + CW'(1);
                    CNT_DEC: count_reg <= count_reg - CW'(1);
                    default: count_reg <= count_reg;
                endcase
            end
            if (cmd.div_start)
            begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= 5'd16;
            end
            else if (div_busy_reg)
            begin
                div_cnt_reg <= div_cnt_reg - 5'd1;
                if (div_cnt_reg == 5'd1) div_busy_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.idle && req.valid)
        begin
            op_reg    <= req.operation;
            len_reg   <= req.block_length;
            start_reg <= req.block_start;
            align_reg <= (req.align_to == 16'd0) ? 16'd1 : req.align_to;
            idx_reg   <= '0;
        end
        else if (cmd.adv)
        begin
            idx_reg  <= idx_reg + CW'(1);
            prev_reg <= cur_reg;
        end
        if (cmd.cap) cur_reg <= entry;
        if (cmd.div_start)
        begin
            div_rem_reg <= '0;
            div_q_reg   <= entry.base;
        end
        else if (div_busy_reg)
        begin
            div_q_reg <= {div_q_reg[14:0], 1'b0};
            if (div_trial >= {1'b0, align_reg})
                div_rem_reg <= 16'(div_trial - {1'b0, align_reg});
            else
                div_rem_reg <= div_trial[15:0];
        end
        case (cmd.ptr_op)
            PTR_IDX: ptr_reg <= idx_reg;
            PTR_CNT: ptr_reg <= count_reg;
            PTR_INC: ptr_reg <= ptr_inc;
            PTR_DEC: ptr_reg <= ptr_dec;
            default: ptr_reg <= ptr_reg;
        endcase
        if (cmd.set_st) st_reg <= cmd.st_code;
        // Merge, split and insert decision
        if (cmd.decide)
        begin
            need_wr_reg   <= 1'b0;
            need_drop_reg <= 1'b0;
            need_ins_reg  <= 1'b0;
            wr_addr_reg   <= idx_reg;
            wr_data_reg   <= cur_reg;
            ins_addr_reg  <= idx_reg;
            ins_data_reg  <= '{base: start_reg, size: len_reg};
            grant_reg     <= 16'd0;
            if (op_reg == OP_RESERVE)
            begin
                grant_reg <= cur_reg.base + off;
                if (off == 16'd0)
                begin
                    if (cur_reg.size == len_reg)
                    begin
                        need_drop_reg <= 1'b1;
                    end
                    else
                    begin
                        need_wr_reg <= 1'b1;
                        wr_data_reg <= '{base: cur_reg.base + len_reg,
                                         size: cur_reg.size - len_reg};
                    end
                end
                else
                begin
                    need_wr_reg <= 1'b1;
                    wr_data_reg <= '{base: cur_reg.base, size: off};
                    if (rest != len_reg)
                    begin
                        need_ins_reg <= 1'b1;
                        ins_addr_reg <= idx_reg + CW'(1);
                        ins_data_reg <= '{base: cur_reg.base + off + len_reg,
                                          size: rest - len_reg};
                    end
                end
            end
            else if (prev_adj && post_adj)
            begin
                need_wr_reg   <= 1'b1;
                need_drop_reg <= 1'b1;
                wr_addr_reg   <= idx_reg - CW'(1);
                wr_data_reg   <= '{base: prev_reg.base, size: sat_both};
            end
            else if (prev_adj)
            begin
                need_wr_reg <= 1'b1;
                wr_addr_reg <= idx_reg - CW'(1);
                wr_data_reg <= '{base: prev_reg.base, size: sat_prev};
            end
            else if (post_adj)
            begin
                need_wr_reg <= 1'b1;
                wr_data_reg <= '{base: cur_reg.base - len_reg, size: sat_post};
            end
            else
            begin
                need_ins_reg <= 1'b1;
            end
        end
        if (cmd.out_load)
        begin
            out_status_reg <= st_reg;
            out_grant_reg  <= (st_reg == ST_OK) ? grant_reg : 16'd0;
        end
    end

    // Result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign req.ready         = cmd.idle;
    assign cfg.ready         = 1'b1;
    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.granted_start = out_grant_reg;

    // Status to controller
    always_comb
    begin
        stat           = '0;
        stat.req_fire  = req.valid && cmd.idle;
        stat.is_free   = op_reg == OP_FREE;
        stat.cnt_zero  = count_reg == '0;
        stat.scan_last = (idx_reg + CW'(1)) >= count_reg;
        stat.div_done  = !div_busy_reg;
        stat.fit       = {1'b0, cur_reg.size} >= need;
        stat.brk       = cur_reg.base > start_reg;
        stat.need_wr   = need_wr_reg;
        stat.need_drop = need_drop_reg;
        stat.need_ins  = need_ins_reg;
        stat.full_err  = need_ins_reg && (count_reg >= MaxCnt);
        stat.sd_more   = ptr_inc < count_reg;
        stat.su_more   = ptr_reg > ins_addr_reg;
        stat.out_free  = !out_valid_reg || rsp.ready;
    end

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MaxCnt)
        else $error("zone count above table depth");
    a_write_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_sel == WR_SHUP || cmd.wr_sel == WR_INS) |-> ptr_reg <= count_reg)
        else $error("shift-up write beyond table end");
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> div_busy_reg && div_cnt_reg == 5'd16)
        else $error("divider did not start");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.cnt_op == CNT_INC && !cfg.valid) |=> count_reg == $past(count_reg) + CW'(1))
        else $error("zone count did not step");
`endif

endmodule

// File: hdl/first_fit_aligned_zone_allocator.sv
`timescale 1ns / 1ps
// Reserve scans zones in order, using a serial remainder for the alignment;
//   free scans until the first zone above the freed block; table entries are
//   shifted on insert or remove, and the result is handed off via a register.
// One request at a time: a new request is accepted only while idle.
// Reset: table holds one zone {0,0}; writing pool_size reloads it.
// ----------------------------------------------------------------------------
// first_fit_aligned_zone_allocator
// First-fit free-zone allocator with aligned reserve and coalescing free.
// ----------------------------------------------------------------------------
module first_fit_aligned_zone_allocator #(
    parameter int MAX_ZONES = 32
) (
    input logic         clk,
    input logic         rst_n,
    ffaza_req_if.sink   req,
    ffaza_rsp_if.source rsp,
    ffaza_cfg_if.sink   cfg
);
    import ffaza_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    ffaza_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    ffaza_dp #(.MAX_ZONES(MAX_ZONES)) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg),
        .cmd   (cmd),
        .stat  (stat)
    );

endmodule
